// ----- rtl/core/sdspi_pkg.sv -----
// Package for the SD card SPI host sequencer: phase and continuation codes,
// opcodes, status codes and protocol constants. No dependencies.
package sdspi_pkg;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_READ  = 3'd1,
    OP_WRITE = 3'd2,
    OP_BYTE  = 3'd3,
    OP_TICK  = 3'd4
  } opcode_t;

  typedef enum logic [5:0] {
    P_IDLE      = 6'd0,
    P_WAKE      = 6'd1,
    P_CMD_READY = 6'd2,
    P_CMD_SEND  = 6'd3,
    P_CMD_RESP  = 6'd4,
    P_OCR       = 6'd5,
    P_SLEEP     = 6'd6,
    P_CSD_TOKEN = 6'd7,
    P_CSD       = 6'd8,
    P_RD_TOKEN  = 6'd9,
    P_RD_DATA   = 6'd10,
    P_RD_CRC    = 6'd11,
    P_WR_READY  = 6'd12,
    P_WR_TOKEN  = 6'd13,
    P_WR_DATA   = 6'd14,
    P_WR_RESP   = 6'd15,
    P_ST_READY  = 6'd16,
    P_ST_TOKEN  = 6'd17,
    K_CMD0      = 6'd20,
    K_CMD8      = 6'd21,
    K_V2POLL    = 6'd22,
    K_CMD58     = 6'd23,
    K_PROBE     = 6'd24,
    K_V1POLL    = 6'd25,
    K_CMD16     = 6'd26,
    K_CMD9      = 6'd27,
    K_RD        = 6'd28,
    K_RD_STOP   = 6'd29,
    K_WR23      = 6'd30,
    K_WR        = 6'd31,
    K_OCR8      = 6'd32,
    K_OCR58     = 6'd33
  } phase_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_CARD = 3'd1;
  localparam logic [2:0] ST_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_IO_ERR  = 3'd3;
  localparam logic [2:0] ST_NO_INIT = 3'd4;

  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_SD1     = 2'd1;
  localparam logic [1:0] KIND_SD2     = 2'd2;
  localparam logic [1:0] KIND_MMC     = 2'd3;

  localparam logic [7:0] APP_FLAG   = 8'h80;
  localparam logic [7:0] IDX_MASK   = 8'h7F;
  localparam logic [7:0] CMD_PREFIX = 8'h40;
  localparam logic [7:0] CRC_CMD0   = 8'h95;
  localparam logic [7:0] CRC_CMD8   = 8'h87;
  localparam logic [7:0] TOK_START  = 8'hFE;
  localparam logic [7:0] TOK_MULTI  = 8'hFC;
  localparam logic [7:0] TOK_STOP   = 8'hFD;
  localparam logic [7:0] RESP_MASK  = 8'h1F;
  localparam logic [7:0] RESP_OK    = 8'h05;
  localparam logic [7:0] IDLE_BYTE  = 8'hFF;
  localparam logic [31:0] ARG_CMD8  = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS   = 32'h4000_0000;

  // Command codes; the application flag marks commands sent after CMD55.
  localparam logic [7:0] CMD0   = 8'd0;
  localparam logic [7:0] CMD1   = 8'd1;
  localparam logic [7:0] CMD8   = 8'd8;
  localparam logic [7:0] CMD9   = 8'd9;
  localparam logic [7:0] CMD12  = 8'd12;
  localparam logic [7:0] CMD16  = 8'd16;
  localparam logic [7:0] CMD17  = 8'd17;
  localparam logic [7:0] CMD18  = 8'd18;
  localparam logic [7:0] CMD24  = 8'd24;
  localparam logic [7:0] CMD25  = 8'd25;
  localparam logic [7:0] CMD55  = 8'd55;
  localparam logic [7:0] CMD58  = 8'd58;
  localparam logic [7:0] ACMD23 = 8'h80 | 8'd23;
  localparam logic [7:0] ACMD41 = 8'h80 | 8'd41;

  localparam int unsigned SECTOR_BYTES = 512;

  // Request as it travels from the front part to the sequencer.
  typedef struct packed {
    opcode_t     op;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
    logic [31:0] sector_address;
    logic [15:0] sector_count;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_request;
    logic        sel;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  status;
    logic [1:0]  card_kind;
    logic        block_addressed;
    logic [31:0] capacity_blocks;
    logic [15:0] sectors_done;
  } res_t;

endpackage

// ----- rtl/core/sdspi_front.sv -----
// Front part: accepts requests and parks them in a two-entry queue.
// Depends on sdspi_pkg.
module sdspi_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [2:0]      in_opcode,
  input  logic [7:0]      in_rx_byte,
  input  logic [7:0]      in_write_byte,
  input  logic [31:0]     in_sector_address,
  input  logic [15:0]     in_sector_count,
  output logic            q_valid,
  input  logic            q_take,
  output sdspi_pkg::req_t q_req
);
  import sdspi_pkg::*;

  req_t       mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;
  req_t       in_req;

  // Every opcode is queued; the sequencer treats unused codes as no-ops.
  always_comb begin
    in_req.op             = opcode_t'(in_opcode);
    in_req.rx_byte        = in_rx_byte;
    in_req.write_byte     = in_write_byte;
    in_req.sector_address = in_sector_address;
    in_req.sector_count   = in_sector_count;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_req    = mem_r[rptr_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= in_req;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- rtl/core/sdspi_seq.sv -----
// Back part: the card sequencer that handles one request per cycle while its
// two-entry registered output queue has room. Depends on sdspi_pkg.
module sdspi_seq #(
  parameter int unsigned RESPONSE_TRIES = 10,
  parameter int unsigned WAKE_BYTES     = 50
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_write,
  input  logic [15:0]     cfg_timeout_ticks,
  input  logic            q_valid,
  output logic            q_take,
  input  sdspi_pkg::req_t q_req,
  output logic            res_valid,
  input  logic            res_take,
  output sdspi_pkg::res_t res
);
  import sdspi_pkg::*;

  // Sequencer state.
  logic [15:0] tmo_r;
  phase_t      phase_r, phase_nxt, resume_r, resume_nxt;
  logic [7:0]  cidx_r, cidx_nxt;
  logic [31:0] carg_r, carg_nxt;
  logic        app_r, app_nxt;
  logic [9:0]  bcnt_r, bcnt_nxt;
  logic [3:0]  retry_r, retry_nxt;
  logic [15:0] elapsed_r, elapsed_nxt, wait_r, wait_nxt;
  logic [7:0]  regs_r [16];
  logic        reg_we;
  logic [3:0]  reg_wa;
  logic [1:0]  kind_r, kind_nxt;
  logic        addr_r, addr_nxt, ready_r, ready_nxt;
  logic [31:0] size_r, size_nxt;
  logic [15:0] left_r, left_nxt, xdone_r, xdone_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic        sel_r, sel_nxt, multi_r, multi_nxt;
  logic [31:0] xaddr_r, xaddr_nxt;

  // Output queue.
  res_t       oq_r [2];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r;

  logic [7:0] o_tx, o_rb;
  logic       o_req, o_rv, o_done;
  logic       step;
  res_t       res_nxt;

  // Signals derived for the command packet and CSD decode.
  logic [7:0]  pidx;
  logic [31:0] parg;
  logic [9:0]  plen;
  logic [31:0] csd_c1, csd_c0;
  logic [4:0]  csd_n;
  logic [31:0] csd_size;

  assign q_take = q_valid && (ocnt_r != 2'd2);
  assign step   = q_take;

  always_comb begin
    pidx = app_r ? CMD55 : (cidx_r & IDX_MASK);
    parg = app_r ? 32'd0 : carg_r;
    plen = (pidx == CMD12) ? 10'd7 : 10'd6;
  end

  // Capacity from the CSD; version 2 counts in 512 KiB units.
  always_comb begin
    csd_c1 = ({24'd0, regs_r[9]} + {16'd0, regs_r[8], 8'd0} + 32'd1) << 10;
    csd_n  = {1'b0, regs_r[5][3:0]} + {4'd0, regs_r[10][7]}
           + {2'd0, regs_r[9][1:0], 1'b0} + 5'd2;
    csd_c0 = {30'd0, regs_r[8][7:6]} + {22'd0, regs_r[7], 2'd0}
           + {20'd0, regs_r[6][1:0], 10'd0} + 32'd1;
    if (regs_r[0][7:6] == 2'd1) csd_size = csd_c1;
    else if (csd_n >= 5'd9) csd_size = csd_c0 << (csd_n - 5'd9);
    else csd_size = csd_c0 >> (5'd9 - csd_n);
  end

  function automatic logic [7:0] pkt_byte(input logic [9:0] k, input logic [7:0] idx,
                                          input logic [31:0] a);
    logic [7:0] b;
    b = IDLE_BYTE;
    unique case (k)
      10'd0: b = CMD_PREFIX | idx;
      10'd1: b = a[31:24];
      10'd2: b = a[23:16];
      10'd3: b = a[15:8];
      10'd4: b = a[7:0];
      10'd5: b = (idx == CMD0) ? CRC_CMD0 : ((idx == CMD8) ? CRC_CMD8 : 8'h01);
      default: b = IDLE_BYTE;
    endcase
    return b;
  endfunction

  // Next state: one request moves the sequencer by one step.
  always_comb begin
    logic       do_cont, do_begin, do_start, do_fin, do_rdend, do_wrend, blk_ok;
    logic       do_rdstart, do_wrstart, do_ststart, do_ocr;
    logic [7:0] cont_resp, s_code;
    logic [31:0] s_arg;
    phase_t     cont_k, s_k, ocr_k;
    logic [2:0] fin_st;
    logic [31:0] xa;
    logic        v2p, v1p, v2a, v1a;
    logic [7:0]  v1code;
    logic [7:0]  rx;

    phase_nxt = phase_r; resume_nxt = resume_r; cidx_nxt = cidx_r; carg_nxt = carg_r;
    app_nxt = app_r; bcnt_nxt = bcnt_r; retry_nxt = retry_r; elapsed_nxt = elapsed_r;
    wait_nxt = wait_r; kind_nxt = kind_r; addr_nxt = addr_r; ready_nxt = ready_r;
    size_nxt = size_r; left_nxt = left_r; xdone_nxt = xdone_r; stat_nxt = stat_r;
    sel_nxt = sel_r; multi_nxt = multi_r; xaddr_nxt = xaddr_r;
    reg_we = 1'b0; reg_wa = bcnt_r[3:0];
    o_tx = IDLE_BYTE; o_req = 1'b0; o_rb = 8'd0; o_rv = 1'b0; o_done = 1'b0;
    do_cont = 1'b0; do_begin = 1'b0; do_start = 1'b0; do_fin = 1'b0;
    do_rdend = 1'b0; do_wrend = 1'b0; blk_ok = 1'b0; do_ocr = 1'b0;
    do_rdstart = 1'b0; do_wrstart = 1'b0; do_ststart = 1'b0;
    cont_resp = 8'd0; cont_k = P_IDLE; s_code = 8'd0; s_arg = 32'd0; s_k = P_IDLE;
    ocr_k = P_IDLE; fin_st = ST_OK; xa = 32'd0;
    v2p = 1'b0; v1p = 1'b0; v2a = 1'b0; v1a = 1'b0; v1code = cidx_r;
    rx = q_req.rx_byte;

    if (step) begin
      // Request decode.
      if (q_req.op == OP_INIT && phase_r == P_IDLE) begin
        xdone_nxt = 16'd0; sel_nxt = 1'b0; kind_nxt = KIND_UNKNOWN;
        addr_nxt = 1'b0; ready_nxt = 1'b0; bcnt_nxt = 10'd0;
        phase_nxt = P_WAKE; o_tx = IDLE_BYTE; o_req = 1'b1;
      end else if ((q_req.op == OP_READ || q_req.op == OP_WRITE) && phase_r == P_IDLE) begin
        xdone_nxt = 16'd0;
        xa = addr_r ? q_req.sector_address : {q_req.sector_address[22:0], 9'd0};
        if (size_r == 32'd0) begin
          do_fin = 1'b1; fin_st = ST_NO_CARD;
        end else if (!ready_r) begin
          do_fin = 1'b1; fin_st = ST_NO_INIT;
        end else if (q_req.sector_count == 16'd0) begin
          do_fin = 1'b1; fin_st = ST_OK;
        end else begin
          left_nxt = q_req.sector_count;
          multi_nxt = (q_req.sector_count != 16'd1);
          xaddr_nxt = xa;
          do_start = 1'b1; s_arg = xa;
          if (q_req.op == OP_READ) begin
            s_code = multi_nxt ? CMD18 : CMD17; s_k = K_RD;
          end else if (multi_nxt && (kind_r == KIND_SD1 || kind_r == KIND_SD2)) begin
            s_code = ACMD23; s_arg = {16'd0, q_req.sector_count}; s_k = K_WR23;
          end else begin
            s_code = multi_nxt ? CMD25 : CMD24; s_k = K_WR;
          end
        end
      end else if (q_req.op == OP_BYTE) begin
        // Byte exchanged: advance the phase.
        unique case (phase_r)
          P_WAKE: begin
            bcnt_nxt = bcnt_r + 10'd1;
            if (bcnt_nxt < 10'(WAKE_BYTES)) begin
              o_req = 1'b1;
            end else begin
              elapsed_nxt = 16'd0;
              do_start = 1'b1; s_code = CMD0; s_arg = 32'd0; s_k = K_CMD0;
            end
          end
          P_CMD_READY: begin
            if (rx == IDLE_BYTE) begin
              bcnt_nxt = 10'd0; phase_nxt = P_CMD_SEND;
              o_req = 1'b1; o_tx = pkt_byte(10'd0, pidx, parg);
            end else if (wait_r >= tmo_r) begin
              do_cont = 1'b1; cont_resp = IDLE_BYTE;
            end else begin
              o_req = 1'b1;
            end
          end
          P_CMD_SEND: begin
            bcnt_nxt = bcnt_r + 10'd1;
            o_req = 1'b1;
            if (bcnt_nxt < plen) begin
              o_tx = pkt_byte(bcnt_nxt, pidx, parg);
            end else begin
              retry_nxt = 4'(RESPONSE_TRIES); phase_nxt = P_CMD_RESP;
            end
          end
          P_CMD_RESP: begin
            if (rx[7] && retry_r > 4'd1) begin
              retry_nxt = retry_r - 4'd1; o_req = 1'b1;
            end else begin
              do_cont = 1'b1; cont_resp = rx;
            end
          end
          P_OCR: begin
            reg_we = 1'b1; reg_wa = bcnt_r[3:0];
            bcnt_nxt = bcnt_r + 10'd1;
            if (bcnt_nxt < 10'd4) o_req = 1'b1;
            else begin
              do_cont = 1'b1; cont_resp = 8'd0;
            end
          end
          P_CSD_TOKEN: begin
            if (rx == TOK_START) begin
              bcnt_nxt = 10'd0; phase_nxt = P_CSD; o_req = 1'b1;
            end else if (rx != IDLE_BYTE || wait_r >= tmo_r) begin
              do_fin = 1'b1; fin_st = ST_OK;
            end else o_req = 1'b1;
          end
          P_CSD: begin
            reg_we = (bcnt_r < 10'd16); reg_wa = bcnt_r[3:0];
            bcnt_nxt = bcnt_r + 10'd1;
            if (bcnt_nxt < 10'd18) o_req = 1'b1;
            else begin
              size_nxt = csd_size; do_fin = 1'b1; fin_st = ST_OK;
            end
          end
          P_RD_TOKEN: begin
            if (rx == TOK_START) begin
              bcnt_nxt = 10'd0; phase_nxt = P_RD_DATA; o_req = 1'b1;
            end else if (rx != IDLE_BYTE || wait_r >= tmo_r) begin
              do_rdend = 1'b1; blk_ok = 1'b0;
            end else o_req = 1'b1;
          end
          P_RD_DATA: begin
            o_rb = rx; o_rv = 1'b1; o_req = 1'b1;
            bcnt_nxt = bcnt_r + 10'd1;
            if (bcnt_r == 10'(SECTOR_BYTES - 1)) begin
              bcnt_nxt = 10'd0; phase_nxt = P_RD_CRC;
            end
          end
          P_RD_CRC: begin
            bcnt_nxt = bcnt_r + 10'd1;
            if (bcnt_nxt < 10'd2) o_req = 1'b1;
            else begin
              do_rdend = 1'b1; blk_ok = 1'b1;
            end
          end
          P_WR_READY: begin
            if (rx == IDLE_BYTE) begin
              phase_nxt = P_WR_TOKEN; o_req = 1'b1;
              o_tx = multi_r ? TOK_MULTI : TOK_START;
            end else if (wait_r >= tmo_r) begin
              do_wrend = 1'b1; blk_ok = 1'b0;
            end else o_req = 1'b1;
          end
          P_WR_TOKEN: begin
            bcnt_nxt = 10'd0; phase_nxt = P_WR_DATA;
            o_req = 1'b1; o_tx = q_req.write_byte;
          end
          P_WR_DATA: begin
            bcnt_nxt = bcnt_r + 10'd1; o_req = 1'b1;
            if (bcnt_r != 10'(SECTOR_BYTES - 1)) o_tx = q_req.write_byte;
            else begin
              bcnt_nxt = 10'd0; phase_nxt = P_WR_RESP;
            end
          end
          P_WR_RESP: begin
            bcnt_nxt = bcnt_r + 10'd1;
            if (bcnt_nxt < 10'd3) o_req = 1'b1;
            else begin
              do_wrend = 1'b1; blk_ok = ((rx & RESP_MASK) == RESP_OK);
            end
          end
          P_ST_READY: begin
            if (rx == IDLE_BYTE) begin
              phase_nxt = P_ST_TOKEN; o_req = 1'b1; o_tx = TOK_STOP;
            end else if (wait_r >= tmo_r) begin
              xdone_nxt = 16'd0; do_fin = 1'b1; fin_st = ST_OK;
            end else o_req = 1'b1;
          end
          P_ST_TOKEN: begin
            do_fin = 1'b1; fin_st = ST_OK;
          end
          default: ;
        endcase
      end else if (q_req.op == OP_TICK) begin
        if (elapsed_r != 16'hFFFF) elapsed_nxt = elapsed_r + 16'd1;
        if (wait_r != 16'hFFFF) wait_nxt = wait_r + 16'd1;
        if (phase_r == P_SLEEP) begin
          if (resume_r == K_V2POLL) v2p = 1'b1;
          else begin
            v1p = 1'b1; v1code = cidx_r;
          end
        end
      end

      // Command completion, with the CMD55 prefix handled first.
      if (do_cont) begin
        if (app_r) begin
          app_nxt = 1'b0;
          if (cont_resp > 8'd1) cont_k = resume_r;
          else begin
            do_begin = 1'b1; cont_k = P_IDLE;
          end
        end else cont_k = resume_r;
        if (!(app_r && cont_resp <= 8'd1)) begin
          unique case (cont_k)
            K_CMD0: begin
              if (cont_resp == 8'd1) begin
                do_start = 1'b1; s_code = CMD8; s_arg = ARG_CMD8; s_k = K_CMD8;
              end else begin
                do_fin = 1'b1; fin_st = ST_NO_CARD;
              end
            end
            K_CMD8: begin
              if (cont_resp == 8'd1) begin
                do_ocr = 1'b1; ocr_k = K_OCR8;
              end else begin
                do_start = 1'b1; s_code = ACMD41; s_arg = 32'd0; s_k = K_PROBE;
              end
            end
            K_OCR8: begin
              if (regs_r[2] == 8'h01 && (reg_wa == 4'd3 ? rx : regs_r[3]) == 8'hAA)
                v2p = 1'b1;
              else begin
                do_fin = 1'b1; fin_st = ST_IO_ERR;
              end
            end
            K_V2POLL, K_V1POLL: begin
              if (cont_resp != 8'd0) begin
                resume_nxt = cont_k; phase_nxt = P_SLEEP;
              end else if (cont_k == K_V2POLL) v2a = 1'b1;
              else v1a = 1'b1;
            end
            K_CMD58: begin
              if (cont_resp == 8'd0) begin
                do_ocr = 1'b1; ocr_k = K_OCR58;
              end else begin
                do_fin = 1'b1; fin_st = ST_TIMEOUT;
              end
            end
            K_OCR58: begin
              kind_nxt = KIND_SD2; addr_nxt = regs_r[0][6]; ready_nxt = 1'b1;
              size_nxt = 32'd0;
              do_start = 1'b1; s_code = CMD9; s_arg = 32'd0; s_k = K_CMD9;
            end
            K_PROBE: begin
              v1p = 1'b1;
              if (cont_resp <= 8'd1) begin
                kind_nxt = KIND_SD1; v1code = ACMD41;
              end else begin
                kind_nxt = KIND_MMC; v1code = CMD1;
              end
            end
            K_CMD16: begin
              if (cont_resp != 8'd0) begin
                kind_nxt = KIND_UNKNOWN; addr_nxt = 1'b0;
                do_fin = 1'b1; fin_st = ST_TIMEOUT;
              end else begin
                ready_nxt = 1'b1; size_nxt = 32'd0;
                do_start = 1'b1; s_code = CMD9; s_arg = 32'd0; s_k = K_CMD9;
              end
            end
            K_CMD9: begin
              if (cont_resp == 8'd0) begin
                wait_nxt = 16'd0; phase_nxt = P_CSD_TOKEN; o_req = 1'b1;
              end else begin
                do_fin = 1'b1; fin_st = ST_OK;
              end
            end
            K_RD: begin
              if (cont_resp != 8'd0) begin
                do_fin = 1'b1; fin_st = ST_IO_ERR;
              end else do_rdstart = 1'b1;
            end
            K_RD_STOP: begin
              do_fin = 1'b1; fin_st = ST_OK;
            end
            K_WR23: begin
              do_start = 1'b1; s_code = CMD25; s_arg = xaddr_r; s_k = K_WR;
            end
            K_WR: begin
              if (cont_resp != 8'd0) begin
                do_fin = 1'b1; fin_st = ST_IO_ERR;
              end else do_wrstart = 1'b1;
            end
            default: begin
              do_fin = 1'b1; fin_st = ST_IO_ERR;
            end
          endcase
        end
      end

      // Polling loops: a poll past the init deadline moves to its follow-up.
      // The deadline is checked against the tick count including this request.
      if (v2p) begin
        if (elapsed_nxt >= tmo_r) v2a = 1'b1;
        else begin
          do_start = 1'b1; s_code = ACMD41; s_arg = ARG_HCS; s_k = K_V2POLL;
        end
      end
      if (v1p) begin
        if (elapsed_nxt >= tmo_r) v1a = 1'b1;
        else begin
          do_start = 1'b1; s_code = v1code; s_arg = 32'd0; s_k = K_V1POLL;
        end
      end
      if (v2a) begin
        if (elapsed_nxt >= tmo_r) begin
          do_fin = 1'b1; fin_st = ST_TIMEOUT;
        end else begin
          do_start = 1'b1; s_code = CMD58; s_arg = 32'd0; s_k = K_CMD58;
        end
      end
      if (v1a) begin
        if (elapsed_nxt >= tmo_r) begin
          kind_nxt = KIND_UNKNOWN; addr_nxt = 1'b0;
          do_fin = 1'b1; fin_st = ST_TIMEOUT;
        end else begin
          do_start = 1'b1; s_code = CMD16; s_arg = 32'(SECTOR_BYTES); s_k = K_CMD16;
        end
      end

      // Block completion for read and write transfers.
      if (do_rdend || do_wrend) begin
        if (!multi_r) begin
          if (blk_ok) xdone_nxt = 16'd1;
          do_fin = 1'b1; fin_st = blk_ok ? ST_OK : ST_IO_ERR;
        end else begin
          if (blk_ok) begin
            xdone_nxt = xdone_r + 16'd1;
            left_nxt = left_r - 16'd1;
          end
          if (blk_ok && left_nxt != 16'd0) begin
            if (do_rdend) do_rdstart = 1'b1;
            else do_wrstart = 1'b1;
          end else if (do_rdend) begin
            do_start = 1'b1; s_code = CMD12; s_arg = 32'd0; s_k = K_RD_STOP;
          end else do_ststart = 1'b1;
        end
      end

      if (do_ocr) begin
        bcnt_nxt = 10'd0; resume_nxt = ocr_k; phase_nxt = P_OCR; o_req = 1'b1;
      end
      if (do_rdstart) begin
        wait_nxt = 16'd0; phase_nxt = P_RD_TOKEN; o_req = 1'b1;
      end
      if (do_wrstart) begin
        wait_nxt = 16'd0; phase_nxt = P_WR_READY; o_req = 1'b1;
      end
      if (do_ststart) begin
        wait_nxt = 16'd0; phase_nxt = P_ST_READY; o_req = 1'b1;
      end
      if (do_start) begin
        cidx_nxt = s_code; carg_nxt = s_arg; resume_nxt = s_k;
        app_nxt = s_code[7];
        do_begin = 1'b1;
      end
      if (do_begin) begin
        sel_nxt = 1'b1; wait_nxt = 16'd0; phase_nxt = P_CMD_READY;
        o_req = 1'b1; o_tx = IDLE_BYTE;
      end
      if (do_fin) begin
        phase_nxt = P_IDLE; sel_nxt = 1'b0; stat_nxt = fin_st; o_done = 1'b1;
        o_req = 1'b0; o_tx = IDLE_BYTE;
      end
    end
  end

  // Result assembly from the state after this step.
  always_comb begin
    res_nxt.tx_byte         = o_tx;
    res_nxt.tx_request      = o_req;
    res_nxt.sel             = sel_nxt;
    res_nxt.read_byte       = o_rb;
    res_nxt.read_valid      = o_rv;
    res_nxt.busy_res        = (phase_nxt != P_IDLE);
    res_nxt.done_res        = o_done;
    res_nxt.status          = stat_nxt;
    res_nxt.card_kind       = kind_nxt;
    res_nxt.block_addressed = addr_nxt;
    res_nxt.capacity_blocks = size_nxt;
    res_nxt.sectors_done    = xdone_nxt;
  end

  // Register file for OCR and CSD bytes.
  always_ff @(posedge clk) begin
    if (step && reg_we) regs_r[reg_wa] <= q_req.rx_byte;
  end

  // Payload registers of the sequencer.
  always_ff @(posedge clk) begin
    if (step) begin
      carg_r  <= carg_nxt;
      xaddr_r <= xaddr_nxt;
    end
  end

  // Control state of the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r <= 16'd500; phase_r <= P_IDLE; resume_r <= P_IDLE; cidx_r <= 8'd0;
      app_r <= 1'b0; bcnt_r <= 10'd0; retry_r <= 4'd0; elapsed_r <= 16'd0;
      wait_r <= 16'd0; kind_r <= KIND_UNKNOWN; addr_r <= 1'b0; ready_r <= 1'b0;
      size_r <= 32'd0; left_r <= 16'd0; xdone_r <= 16'd0; stat_r <= ST_OK;
      sel_r <= 1'b0; multi_r <= 1'b0;
    end else begin
      if (cfg_write) tmo_r <= cfg_timeout_ticks;
      if (step) begin
        phase_r <= phase_nxt; resume_r <= resume_nxt; cidx_r <= cidx_nxt;
        app_r <= app_nxt; bcnt_r <= bcnt_nxt; retry_r <= retry_nxt;
        elapsed_r <= elapsed_nxt; wait_r <= wait_nxt; kind_r <= kind_nxt;
        addr_r <= addr_nxt; ready_r <= ready_nxt; size_r <= size_nxt;
        left_r <= left_nxt; xdone_r <= xdone_nxt; stat_r <= stat_nxt;
        sel_r <= sel_nxt; multi_r <= multi_nxt;
      end
    end
  end

  // Output queue keeps results while the receiver stalls.
  always_ff @(posedge clk) begin
    if (step) oq_r[owp_r] <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r <= 1'b0; orp_r <= 1'b0; ocnt_r <= 2'd0;
    end else begin
      if (step) owp_r <= ~owp_r;
      if (res_valid && res_take) orp_r <= ~orp_r;
      ocnt_r <= ocnt_r + {1'b0, step} - {1'b0, res_valid && res_take};
    end
  end

  assign res_valid = (ocnt_r != 2'd0);
  assign res       = oq_r[orp_r];
endmodule

// ----- rtl/core/sd_card_spi_host_sequencer_top.sv -----
// SD card SPI-mode host sequencer, top level.
// Holds the request front part and the sequencer; depends on sdspi_pkg,
// sdspi_front and sdspi_seq.
//
// Usage: each input request is one opcode: an init, read or write request,
// a byte-exchanged report carrying the byte received from the card, or a
// millisecond tick. Every request yields exactly one result naming the next
// byte to exchange, chip select, received sector data and status. Opcodes
// 5 to 7 change nothing and return the current status fields.
// A request passes the input queue register, then the sequencer step writes
// its result into the output queue register; the step waits while that
// queue is full. Throughput is one request per cycle while the output queue
// has room; the sequencer does one step per request in its next-state logic.
// A two-entry queue sits on each side, so a stalled receiver fills the output
// queue and then the input queue before in_stall rises.
// Reset (rst_n low, synchronous) empties both queues, returns the sequencer
// to idle with card kind unknown and capacity zero, and sets the timeout to
// 500 ticks. The user writes cfg_timeout_ticks only while the block is idle;
// the block itself does not enforce this.
module sd_card_spi_host_sequencer_top #(
  parameter int unsigned RESPONSE_TRIES = 10,
  parameter int unsigned WAKE_BYTES     = 50
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write,
  input  logic [15:0] cfg_timeout_ticks,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_write_byte,
  input  logic [31:0] in_sector_address,
  input  logic [15:0] in_sector_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_request,
  output logic        out_select,
  output logic [7:0]  out_read_byte,
  output logic        out_read_valid,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  output logic [1:0]  out_card_kind,
  output logic        out_block_addressed,
  output logic [31:0] out_capacity_blocks,
  output logic [15:0] out_sectors_done
);
  import sdspi_pkg::*;

  logic q_valid, q_take;
  req_t q_req;
  res_t res;

  sdspi_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_rx_byte, .in_write_byte,
    .in_sector_address, .in_sector_count, .q_valid, .q_take, .q_req
  );

  sdspi_seq #(
    .RESPONSE_TRIES(RESPONSE_TRIES),
    .WAKE_BYTES    (WAKE_BYTES)
  ) u_seq (
    .clk, .rst_n, .cfg_write, .cfg_timeout_ticks, .q_valid, .q_take, .q_req,
    .res_valid(out_valid), .res_take(!out_stall), .res
  );

  // Result fields onto the output ports.
  assign out_tx_byte         = res.tx_byte;
  assign out_tx_request      = res.tx_request;
  assign out_select          = res.sel;
  assign out_read_byte       = res.read_byte;
  assign out_read_valid      = res.read_valid;
  assign out_busy_res        = res.busy_res;
  assign out_done_res        = res.done_res;
  assign out_status          = res.status;
  assign out_card_kind       = res.card_kind;
  assign out_block_addressed = res.block_addressed;
  assign out_capacity_blocks = res.capacity_blocks;
  assign out_sectors_done    = res.sectors_done;
endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for sd_card_spi_host_sequencer_top: a card emulator
// builds request streams, an in-bench sequencer predictor computes every result.
// Depends on sdspi_pkg and the block's RTL.
module tb_top;
  import sdspi_pkg::*;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  rx;
    logic [7:0]  wb;
    logic [31:0] sa;
    logic [15:0] sc;
  } item_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_write;
  logic [15:0] cfg_timeout_ticks;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_opcode;
  logic [7:0]  in_rx_byte;
  logic [7:0]  in_write_byte;
  logic [31:0] in_sector_address;
  logic [15:0] in_sector_count;
  logic        out_valid;
  logic        out_stall;
  res_t        act;

  sd_card_spi_host_sequencer_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_write           (cfg_write),
    .cfg_timeout_ticks   (cfg_timeout_ticks),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_rx_byte          (in_rx_byte),
    .in_write_byte       (in_write_byte),
    .in_sector_address   (in_sector_address),
    .in_sector_count     (in_sector_count),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_tx_byte         (act.tx_byte),
    .out_tx_request      (act.tx_request),
    .out_select          (act.sel),
    .out_read_byte       (act.read_byte),
    .out_read_valid      (act.read_valid),
    .out_busy_res        (act.busy_res),
    .out_done_res        (act.done_res),
    .out_status          (act.status),
    .out_card_kind       (act.card_kind),
    .out_block_addressed (act.block_addressed),
    .out_capacity_blocks (act.capacity_blocks),
    .out_sectors_done    (act.sectors_done)
  );

  item_t pending_reqs[$];
  res_t  expected_res[$];
  int    fails;
  int    results_seen;

  // Sequencer state as predicted.
  phase_t      sq_phase, sq_resume;
  logic [7:0]  cmd_code;
  logic [31:0] cmd_arg, cap_blocks, xfer_addr;
  logic        app_pend, addr_blk, card_ready, sel_held, multi;
  int          bcnt, tries;
  logic [15:0] init_ticks, wait_ticks, sectors_left, moved, tmo;
  logic [7:0]  regs [16];
  logic [1:0]  kind;
  logic [2:0]  last_st;
  logic [7:0]  o_tx, o_rb;
  logic        o_req, o_rv, o_done;

  // Card emulator choices for the running request.
  int   card_type;
  bit   no_card;
  int   polls_left;
  bit   abort_xfer;

  function void send(logic [7:0] b);
    o_tx = b;
    o_req = 1'b1;
  endfunction

  function void finish_req(logic [2:0] st);
    sq_phase = P_IDLE;
    sel_held = 1'b0;
    last_st = st;
    o_done = 1'b1;
  endfunction

  function void cmd_go();
    sel_held = 1'b1;
    wait_ticks = 0;
    sq_phase = P_CMD_READY;
    send(IDLE_BYTE);
  endfunction

  function void issue(logic [7:0] code, logic [31:0] arg, phase_t cont);
    cmd_code = code;
    cmd_arg = arg;
    sq_resume = cont;
    app_pend = (code & APP_FLAG) != 0;
    cmd_go();
  endfunction

  function logic [7:0] pkt_idx();
    return app_pend ? CMD55 : (cmd_code & IDX_MASK);
  endfunction

  function logic [7:0] pkt_byte(int k);
    logic [7:0]  idx;
    logic [31:0] a;
    idx = pkt_idx();
    a = app_pend ? 32'd0 : cmd_arg;
    case (k)
      0: return CMD_PREFIX | idx;
      1: return a[31:24];
      2: return a[23:16];
      3: return a[15:8];
      4: return a[7:0];
      5: return idx == CMD0 ? CRC_CMD0 : (idx == CMD8 ? CRC_CMD8 : 8'h01);
      default: return IDLE_BYTE;
    endcase
  endfunction

  function void cmd_resp(logic [7:0] resp);
    if (app_pend) begin
      app_pend = 1'b0;
      if (resp > 1) resume(sq_resume, resp);
      else cmd_go();
    end else begin
      resume(sq_resume, resp);
    end
  endfunction

  function void ocr_go(phase_t k);
    bcnt = 0;
    sq_resume = k;
    sq_phase = P_OCR;
    send(IDLE_BYTE);
  endfunction

  function void v2_after();
    if (init_ticks >= tmo) finish_req(ST_TIMEOUT);
    else issue(CMD58, 0, K_CMD58);
  endfunction

  function void v2_poll();
    if (init_ticks >= tmo) v2_after();
    else issue(ACMD41, ARG_HCS, K_V2POLL);
  endfunction

  function void v1_after();
    if (init_ticks >= tmo) begin
      kind = KIND_UNKNOWN;
      addr_blk = 1'b0;
      finish_req(ST_TIMEOUT);
    end else begin
      issue(CMD16, SECTOR_BYTES, K_CMD16);
    end
  endfunction

  function void v1_poll(logic [7:0] code);
    if (init_ticks >= tmo) v1_after();
    else issue(code, 0, K_V1POLL);
  endfunction

  function void csd_go();
    cap_blocks = 0;
    issue(CMD9, 0, K_CMD9);
  endfunction

  // CSD version 2 gives C_SIZE in 512 KiB units; version 1 uses the exponent form.
  function void csd_decode();
    logic [31:0] c, n;
    if (regs[0][7:6] == 2'd1) begin
      c = {16'd0, regs[8], regs[9]} + 1;
      cap_blocks = c << 10;
    end else begin
      n = regs[5][3:0] + regs[10][7] + (regs[9][1:0] << 1) + 2;
      c = regs[8][7:6] + (regs[7] << 2) + (regs[6][1:0] << 10) + 1;
      cap_blocks = n >= 9 ? c << (n - 9) : c >> (9 - n);
    end
  endfunction

  function void rd_go();
    wait_ticks = 0;
    sq_phase = P_RD_TOKEN;
    send(IDLE_BYTE);
  endfunction

  function void rd_end(bit ok);
    if (!multi) begin
      if (ok) moved = 1;
      finish_req(ok ? ST_OK : ST_IO_ERR);
    end else if (ok) begin
      moved++;
      sectors_left--;
      if (sectors_left != 0) rd_go();
      else issue(CMD12, 0, K_RD_STOP);
    end else begin
      issue(CMD12, 0, K_RD_STOP);
    end
  endfunction

  function void wr_go();
    wait_ticks = 0;
    sq_phase = P_WR_READY;
    send(IDLE_BYTE);
  endfunction

  function void stop_go();
    wait_ticks = 0;
    sq_phase = P_ST_READY;
    send(IDLE_BYTE);
  endfunction

  function void wr_end(bit ok);
    if (!multi) begin
      if (ok) moved = 1;
      finish_req(ok ? ST_OK : ST_IO_ERR);
    end else if (ok) begin
      moved++;
      sectors_left--;
      if (sectors_left != 0) wr_go();
      else stop_go();
    end else begin
      stop_go();
    end
  endfunction

  // What the sequencer does once a command's response (or a register) is in.
  function void resume(phase_t k, logic [7:0] resp);
    case (k)
      K_CMD0: if (resp == 1) issue(CMD8, ARG_CMD8, K_CMD8); else finish_req(ST_NO_CARD);
      K_CMD8: if (resp == 1) ocr_go(K_OCR8); else issue(ACMD41, 0, K_PROBE);
      K_OCR8: begin
        if (regs[2] == 8'h01 && regs[3] == 8'hAA) v2_poll();
        else finish_req(ST_IO_ERR);
      end
      K_V2POLL, K_V1POLL: begin
        if (resp != 0) begin
          sq_resume = k;
          sq_phase = P_SLEEP;
        end else if (k == K_V2POLL) v2_after();
        else v1_after();
      end
      K_CMD58: if (resp == 0) ocr_go(K_OCR58); else finish_req(ST_TIMEOUT);
      K_OCR58: begin
        kind = KIND_SD2;
        addr_blk = regs[0][6];
        card_ready = 1'b1;
        csd_go();
      end
      K_PROBE: begin
        if (resp <= 1) begin
          kind = KIND_SD1;
          v1_poll(ACMD41);
        end else begin
          kind = KIND_MMC;
          v1_poll(CMD1);
        end
      end
      K_CMD16: begin
        if (resp != 0) begin
          kind = KIND_UNKNOWN;
          addr_blk = 1'b0;
          finish_req(ST_TIMEOUT);
        end else begin
          card_ready = 1'b1;
          csd_go();
        end
      end
      K_CMD9: begin
        if (resp == 0) begin
          wait_ticks = 0;
          sq_phase = P_CSD_TOKEN;
          send(IDLE_BYTE);
        end else finish_req(ST_OK);
      end
      K_RD: if (resp != 0) finish_req(ST_IO_ERR); else rd_go();
      K_RD_STOP: finish_req(ST_OK);
      K_WR23: issue(CMD25, xfer_addr, K_WR);
      K_WR: if (resp != 0) finish_req(ST_IO_ERR); else wr_go();
      default: finish_req(ST_IO_ERR);
    endcase
  endfunction

  function void on_byte(logic [7:0] rx, logic [7:0] wb);
    case (sq_phase)
      P_WAKE: begin
        bcnt++;
        if (bcnt < 50) send(IDLE_BYTE);
        else begin
          init_ticks = 0;
          issue(CMD0, 0, K_CMD0);
        end
      end
      P_CMD_READY: begin
        if (rx == IDLE_BYTE) begin
          bcnt = 0;
          sq_phase = P_CMD_SEND;
          send(pkt_byte(0));
        end else if (wait_ticks >= tmo) cmd_resp(8'hFF);
        else send(IDLE_BYTE);
      end
      P_CMD_SEND: begin
        bcnt++;
        if (bcnt < (pkt_idx() == CMD12 ? 7 : 6)) send(pkt_byte(bcnt));
        else begin
          tries = 10;
          sq_phase = P_CMD_RESP;
          send(IDLE_BYTE);
        end
      end
      P_CMD_RESP: begin
        if (rx[7] && tries > 1) begin
          tries--;
          send(IDLE_BYTE);
        end else cmd_resp(rx);
      end
      P_OCR: begin
        regs[bcnt & 15] = rx;
        bcnt++;
        if (bcnt < 4) send(IDLE_BYTE);
        else resume(sq_resume, 0);
      end
      P_CSD_TOKEN: begin
        if (rx == TOK_START) begin
          bcnt = 0;
          sq_phase = P_CSD;
          send(IDLE_BYTE);
        end else if (rx != IDLE_BYTE || wait_ticks >= tmo) finish_req(ST_OK);
        else send(IDLE_BYTE);
      end
      P_CSD: begin
        if (bcnt < 16) regs[bcnt] = rx;
        bcnt++;
        if (bcnt < 18) send(IDLE_BYTE);
        else begin
          csd_decode();
          finish_req(ST_OK);
        end
      end
      P_RD_TOKEN: begin
        if (rx == TOK_START) begin
          bcnt = 0;
          sq_phase = P_RD_DATA;
          send(IDLE_BYTE);
        end else if (rx != IDLE_BYTE || wait_ticks >= tmo) rd_end(0);
        else send(IDLE_BYTE);
      end
      P_RD_DATA: begin
        o_rb = rx;
        o_rv = 1'b1;
        bcnt++;
        if (bcnt >= SECTOR_BYTES) begin
          bcnt = 0;
          sq_phase = P_RD_CRC;
        end
        send(IDLE_BYTE);
      end
      P_RD_CRC: begin
        bcnt++;
        if (bcnt < 2) send(IDLE_BYTE);
        else rd_end(1);
      end
      P_WR_READY: begin
        if (rx == IDLE_BYTE) begin
          sq_phase = P_WR_TOKEN;
          send(multi ? TOK_MULTI : TOK_START);
        end else if (wait_ticks >= tmo) wr_end(0);
        else send(IDLE_BYTE);
      end
      P_WR_TOKEN: begin
        bcnt = 0;
        sq_phase = P_WR_DATA;
        send(wb);
      end
      P_WR_DATA: begin
        bcnt++;
        if (bcnt < SECTOR_BYTES) send(wb);
        else begin
          bcnt = 0;
          sq_phase = P_WR_RESP;
          send(IDLE_BYTE);
        end
      end
      P_WR_RESP: begin
        bcnt++;
        if (bcnt < 3) send(IDLE_BYTE);
        else wr_end((rx & RESP_MASK) == RESP_OK);
      end
      P_ST_READY: begin
        if (rx == IDLE_BYTE) begin
          sq_phase = P_ST_TOKEN;
          send(TOK_STOP);
        end else if (wait_ticks >= tmo) begin
          moved = 0;
          finish_req(ST_OK);
        end else send(IDLE_BYTE);
      end
      P_ST_TOKEN: finish_req(ST_OK);
      default: ;
    endcase
  endfunction

  function void start_xfer(bit wr, logic [31:0] sa, logic [15:0] sc);
    moved = 0;
    if (cap_blocks == 0) finish_req(ST_NO_CARD);
    else if (!card_ready) finish_req(ST_NO_INIT);
    else if (sc == 0) finish_req(ST_OK);
    else begin
      sectors_left = sc;
      multi = sc != 1;
      xfer_addr = addr_blk ? sa : sa * SECTOR_BYTES;
      if (!wr) issue(multi ? CMD18 : CMD17, xfer_addr, K_RD);
      else if (multi && (kind == KIND_SD1 || kind == KIND_SD2))
        issue(ACMD23, {16'd0, sc}, K_WR23);
      else issue(multi ? CMD25 : CMD24, xfer_addr, K_WR);
    end
  endfunction

  function res_t predict_step(item_t it);
    res_t r;
    o_tx = IDLE_BYTE;
    o_req = 0;
    o_rb = 0;
    o_rv = 0;
    o_done = 0;
    if (it.op == OP_INIT && sq_phase == P_IDLE) begin
      moved = 0;
      sel_held = 0;
      kind = KIND_UNKNOWN;
      addr_blk = 0;
      card_ready = 0;
      bcnt = 0;
      sq_phase = P_WAKE;
      send(IDLE_BYTE);
    end else if ((it.op == OP_READ || it.op == OP_WRITE) && sq_phase == P_IDLE) begin
      start_xfer(it.op == OP_WRITE, it.sa, it.sc);
    end else if (it.op == OP_BYTE) begin
      on_byte(it.rx, it.wb);
    end else if (it.op == OP_TICK) begin
      if (init_ticks != 16'hFFFF) init_ticks++;
      if (wait_ticks != 16'hFFFF) wait_ticks++;
      if (sq_phase == P_SLEEP) begin
        if (sq_resume == K_V2POLL) v2_poll();
        else v1_poll(cmd_code);
      end
    end
    r.tx_byte = o_tx;
    r.tx_request = o_req;
    r.sel = sel_held;
    r.read_byte = o_rb;
    r.read_valid = o_rv;
    r.busy_res = sq_phase != P_IDLE;
    r.done_res = o_done;
    r.status = last_st;
    r.card_kind = kind;
    r.block_addressed = addr_blk;
    r.capacity_blocks = cap_blocks;
    r.sectors_done = moved;
    return r;
  endfunction

  // Every request, unused opcodes included, yields one result.
  task automatic add_req(logic [2:0] op, logic [7:0] rx, logic [31:0] sa, logic [15:0] sc);
    item_t it;
    it.op = op;
    it.rx = rx;
    it.wb = $urandom;
    it.sa = sa;
    it.sc = sc;
    pending_reqs.push_back(it);
    expected_res.push_back(predict_step(it));
  endtask

  // Card side: answers with a plausible byte for the phase the sequencer is in.
  task automatic card_step();
    int          r;
    logic [7:0]  rx;
    logic [7:0]  idx;
    logic [7:0]  ocr8 [4];
    ocr8 = '{8'h00, 8'h00, 8'h01, 8'hAA};
    r = $urandom_range(0, 99);
    rx = $urandom;
    idx = pkt_idx();
    if (sq_phase == P_SLEEP || r < 8) begin
      add_req(OP_TICK, rx, $urandom, $urandom);
    end else if (r < 10) begin
      add_req($urandom_range(5, 7), rx, $urandom, $urandom);
    end else if (r < 12 && sq_phase != P_IDLE) begin
      add_req($urandom_range(0, 2), rx, $urandom, $urandom);
    end else if (sq_phase == P_IDLE) begin
      r = $urandom_range(0, 99);
      abort_xfer = 0;
      if (!card_ready || r < 10) begin
        card_type = $urandom_range(0, 2);
        no_card = $urandom_range(0, 19) == 0;
        polls_left = $urandom_range(0, 3);
        add_req(OP_INIT, rx, $urandom, $urandom);
      end else if (r < 15) begin
        add_req($urandom_range(1, 2), rx, $urandom, 16'd0);
      end else if (r < 22) begin
        abort_xfer = 1;
        add_req($urandom_range(1, 2), rx, $urandom, $urandom_range(2, 65535));
      end else begin
        add_req($urandom_range(1, 2), rx, $urandom, $urandom_range(1, 2));
      end
    end else begin
      case (sq_phase)
        P_CMD_READY, P_WR_READY, P_ST_READY: if ($urandom_range(0, 9) != 0) rx = IDLE_BYTE;
        P_CMD_RESP: begin
          if ($urandom_range(0, 3) != 0) begin
            if (idx == CMD55) rx = 8'h01;
            else if (idx == CMD0) rx = no_card ? 8'h00 : 8'h01;
            else if (idx == CMD8) rx = card_type == 0 ? 8'h01 : 8'h05;
            else if (cmd_code == ACMD41 && sq_resume == K_PROBE)
              rx = card_type == 1 ? 8'h01 : 8'h05;
            else if (sq_resume == K_V2POLL || sq_resume == K_V1POLL) begin
              rx = polls_left > 0 ? 8'h01 : 8'h00;
              if (polls_left > 0) polls_left--;
            end else rx = $urandom_range(0, 29) == 0 ? 8'h04 : 8'h00;
          end else rx = 8'h80 | rx;
        end
        P_OCR: if (sq_resume == K_OCR8 && $urandom_range(0, 19) != 0) rx = ocr8[bcnt & 3];
        P_CSD_TOKEN: if ($urandom_range(0, 9) != 0) rx = TOK_START; else rx = IDLE_BYTE;
        P_RD_TOKEN: begin
          if (abort_xfer) rx = 8'h0B;
          else if ($urandom_range(0, 9) != 0) rx = TOK_START;
          else rx = IDLE_BYTE;
        end
        P_WR_RESP: begin
          if (abort_xfer) rx = 8'h0D;
          else if ($urandom_range(0, 19) != 0) rx = {rx[7:5], 5'h05};
        end
        default: ;
      endcase
      add_req(OP_BYTE, rx, $urandom, $urandom);
    end
  endtask

  // Clock and timeout watchdog.
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Driver: presents queued requests, holds them while stalled.
  logic in_took;
  int   send_gap;

  always @(posedge clk) begin
    in_took <= in_valid && !in_stall;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    item_t it;
    if (rst_n) begin
      if (in_valid && !in_took) begin
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (pending_reqs.size() > 0) begin
        it = pending_reqs.pop_front();
        in_opcode <= it.op;
        in_rx_byte <= it.rx;
        in_write_byte <= it.wb;
        in_sector_address <= it.sa;
        in_sector_count <= it.sc;
        in_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with one long hold-off to back the block up.
  int  stall_left;
  bit  long_hold_done;

  always @(negedge clk) begin
    if (rst_n) begin
      if (!long_hold_done && results_seen >= 150) begin
        long_hold_done = 1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // Monitor: compares each accepted result with the oldest prediction.
  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected %0h, got %0h", name, e, a);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_res.size() == 0) begin
        $error("result with no request outstanding");
        fails++;
      end else begin
        e = expected_res.pop_front();
        check_field("tx_byte", e.tx_byte, act.tx_byte);
        check_field("tx_request", e.tx_request, act.tx_request);
        check_field("select", e.sel, act.sel);
        check_field("read_byte", e.read_byte, act.read_byte);
        check_field("read_valid", e.read_valid, act.read_valid);
        check_field("busy_res", e.busy_res, act.busy_res);
        check_field("done_res", e.done_res, act.done_res);
        check_field("status", e.status, act.status);
        check_field("card_kind", e.card_kind, act.card_kind);
        check_field("block_addressed", e.block_addressed, act.block_addressed);
        check_field("capacity_blocks", e.capacity_blocks, act.capacity_blocks);
        check_field("sectors_done", e.sectors_done, act.sectors_done);
      end
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_res.size() > 0 || in_valid)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Stimulus: directed corner cases, then random phases over timeout settings.
  // The request budget is shared across phases; a phase that runs long
  // leaves less for the ones after it.
  initial begin
    logic [15:0] tmo_set [5];
    int          total;
    fails = 0;
    results_seen = 0;
    send_gap = 0;
    stall_left = 0;
    long_hold_done = 0;
    total = 0;
    rst_n = 0;
    cfg_write = 0;
    cfg_timeout_ticks = 0;
    in_valid = 0;
    in_opcode = OP_TICK;
    in_rx_byte = 0;
    in_write_byte = 0;
    in_sector_address = 0;
    in_sector_count = 0;
    out_stall = 0;

    sq_phase = P_IDLE;
    sq_resume = P_IDLE;
    cmd_code = 0;
    cmd_arg = 0;
    app_pend = 0;
    bcnt = 0;
    tries = 0;
    init_ticks = 0;
    wait_ticks = 0;
    foreach (regs[i]) regs[i] = 0;
    kind = KIND_UNKNOWN;
    addr_blk = 0;
    card_ready = 0;
    cap_blocks = 0;
    sectors_left = 0;
    moved = 0;
    last_st = ST_OK;
    sel_held = 0;
    multi = 0;
    xfer_addr = 0;
    tmo = 500;

    // Unused opcodes, idle bytes and ticks, transfers before any init.
    add_req(3'd5, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    add_req(3'd6, 8'h00, 32'h0, 16'h0);
    add_req(3'd7, 8'hA5, 32'h1234_5678, 16'h1);
    add_req(OP_BYTE, 8'hFE, 32'h0, 16'h1);
    add_req(OP_TICK, 8'h00, 32'h0, 16'h1);
    add_req(OP_READ, 8'h00, 32'hFFFF_FFFF, 16'd1);
    add_req(OP_WRITE, 8'hFF, 32'h0, 16'hFFFF);
    add_req(OP_READ, 8'h00, 32'h0, 16'd0);

    tmo_set = '{16'd500, 16'd1, 16'hFFFF, 16'd3, 16'($urandom_range(2, 40))};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        drain();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_timeout_ticks <= tmo_set[ph];
        tmo = tmo_set[ph];
        @(negedge clk);
        cfg_write <= 1'b0;
      end
      while (total < 240 * (ph + 1) || sq_phase != P_IDLE) begin
        card_step();
        total++;
      end
    end
    drain();
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
